@@ design/itwt_pkg.sv @@
`timescale 1ns / 1ps

package itwt_pkg;

    localparam int VALUE_W = 31;
    localparam int CNT_W   = 5;
    localparam int DIGITS  = 12;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int WORD_W  = 5;

    localparam logic [WORD_W-1:0] TOK_ZERO    = 5'd0;
    localparam logic [WORD_W-1:0] TOK_TEN     = 5'd10;
    localparam logic [WORD_W-1:0] TOK_TENS0   = 5'd18;
    localparam logic [WORD_W-1:0] TOK_HUNDRED = 5'd28;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_CONV = 8'b0000_0010,
        ST_ZERO = 8'b0000_0100,
        ST_HD   = 8'b0000_1000,
        ST_HW   = 8'b0001_0000,
        ST_TN   = 8'b0010_0000,
        ST_UN   = 8'b0100_0000,
        ST_SC   = 8'b1000_0000
    } state_t;

endpackage

@@ design/integer_to_word_tokens.sv @@
`timescale 1ns / 1ps

// Names a non-negative integer as a stream of English word tokens.
// The slave channel takes one request per number in s_tdata[30:0]. The master
// channel returns one token per beat in m_tdata[4:0], with m_tlast set on the
// final token of that number.
// A request is taken only while the block is idle. A nonzero value is first
// turned into decimal digits by a shift-and-add-three converter, one bit per
// cycle. A sequencer then walks the billion, million, thousand and unit groups,
// five steps per group at most, counting steps that yield no token, and one
// step for a group that is zero; it returns to idle once the last token is
// given. A value of zero skips the conversion: a zero state loads its single
// token into the output register.
// The output is a register: s_tready rises again once the last token is loaded,
// even while that token still waits. When a token waits with m_tready low, a
// step that would give a token holds and the waiting token stays unchanged.
// Reset empties the output register and returns the block to idle.

module integer_to_word_tokens (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [31:0] s_tdata,  // [30:0] value, [31] zero fill
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] word, [7:5] zero fill
    output logic       m_tlast
);

    itwt_pkg::state_t state_reg, state_next;

    logic [itwt_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [itwt_pkg::BCD_W-1:0]   bcd_reg, bcd_next, bcd_adj;
    logic [itwt_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]                   grp_reg, grp_next;
    logic                         out_valid_reg, out_valid_next;
    logic [itwt_pkg::WORD_W-1:0]  out_word_reg, out_word_next;
    logic                         out_last_reg, out_last_next;

    logic                         in_acc;
    logic                         out_free;
    logic                         emit;
    logic [itwt_pkg::WORD_W-1:0]  emit_word;
    logic                         emit_last;
    logic [3:0]                   dig_h, dig_t, dig_u;
    logic                         grp_nz, rest_zero, last_grp;
    logic [itwt_pkg::WORD_W-1:0]  unit_word;

    assign s_tready = (state_reg == itwt_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign dig_h     = bcd_reg[itwt_pkg::BCD_W-1 -: 4];
    assign dig_t     = bcd_reg[itwt_pkg::BCD_W-5 -: 4];
    assign dig_u     = bcd_reg[itwt_pkg::BCD_W-9 -: 4];
    assign grp_nz    = (bcd_reg[itwt_pkg::BCD_W-1 -: 12] != 12'd0);
    assign rest_zero = (bcd_reg[itwt_pkg::BCD_W-13:0] == '0);
    assign last_grp  = (grp_reg == 2'd0);

    always_comb
    begin
        if (dig_t >= 4'd2)
        begin
            unit_word = {1'b0, dig_u};
        end
        else if (dig_t == 4'd1)
        begin
            unit_word = itwt_pkg::TOK_TEN + {1'b0, dig_u};
        end
        else
        begin
            unit_word = {1'b0, dig_u};
        end
    end

    always_comb
    begin
        for (int i = 0; i < itwt_pkg::DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        grp_next   = grp_reg;
        emit       = 1'b0;
        emit_word  = itwt_pkg::TOK_ZERO;
        emit_last  = 1'b0;

        unique case (state_reg)
            itwt_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    bin_next = s_tdata[itwt_pkg::VALUE_W-1:0];
                    bcd_next = '0;
                    cnt_next = '0;
                    if (s_tdata[itwt_pkg::VALUE_W-1:0] == '0)
                    begin
                        state_next = itwt_pkg::ST_ZERO;
                    end
                    else
                    begin
                        state_next = itwt_pkg::ST_CONV;
                    end
                end
            end
            itwt_pkg::ST_CONV:
            begin
                bcd_next = {bcd_adj[itwt_pkg::BCD_W-2:0], bin_reg[itwt_pkg::VALUE_W-1]};
                bin_next = {bin_reg[itwt_pkg::VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == itwt_pkg::CNT_W'(itwt_pkg::VALUE_W - 1))
                begin
                    grp_next   = 2'd3;
                    state_next = itwt_pkg::ST_HD;
                end
            end
            itwt_pkg::ST_ZERO:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_word  = itwt_pkg::TOK_ZERO;
                    emit_last  = 1'b1;
                    state_next = itwt_pkg::ST_IDLE;
                end
            end
            itwt_pkg::ST_HD:
            begin
                if (!grp_nz)
                begin
                    if (last_grp)
                    begin
                        state_next = itwt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        bcd_next = {bcd_reg[itwt_pkg::BCD_W-13:0], 12'd0};
                        grp_next = grp_reg - 2'd1;
                    end
                end
                else if (dig_h == 4'd0)
                begin
                    state_next = itwt_pkg::ST_TN;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_word  = {1'b0, dig_h};
                    state_next = itwt_pkg::ST_HW;
                end
            end
            itwt_pkg::ST_HW:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_word  = itwt_pkg::TOK_HUNDRED;
                    emit_last  = last_grp && (dig_t == 4'd0) && (dig_u == 4'd0);
                    state_next = emit_last ? itwt_pkg::ST_IDLE : itwt_pkg::ST_TN;
                end
            end
            itwt_pkg::ST_TN:
            begin
                if (dig_t < 4'd2)
                begin
                    state_next = itwt_pkg::ST_UN;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_word  = itwt_pkg::TOK_TENS0 + {1'b0, dig_t};
                    emit_last  = last_grp && (dig_u == 4'd0);
                    state_next = emit_last ? itwt_pkg::ST_IDLE : itwt_pkg::ST_UN;
                end
            end
            itwt_pkg::ST_UN:
            begin
                if (unit_word == itwt_pkg::TOK_ZERO)
                begin
                    state_next = last_grp ? itwt_pkg::ST_IDLE : itwt_pkg::ST_SC;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_word  = unit_word;
                    emit_last  = last_grp;
                    state_next = last_grp ? itwt_pkg::ST_IDLE : itwt_pkg::ST_SC;
                end
            end
            itwt_pkg::ST_SC:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_word = itwt_pkg::TOK_HUNDRED + {3'd0, grp_reg};
                    emit_last = rest_zero;
                    if (rest_zero)
                    begin
                        state_next = itwt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        bcd_next   = {bcd_reg[itwt_pkg::BCD_W-13:0], 12'd0};
                        grp_next   = grp_reg - 2'd1;
                        state_next = itwt_pkg::ST_HD;
                    end
                end
            end
            default:
            begin
                state_next = itwt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = emit_word;
            out_last_next  = emit_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itwt_pkg::ST_IDLE;
            cnt_reg       <= '0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_word_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ design/itwt_checker.sv @@
`timescale 1ns / 1ps

module itwt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [31:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("Stalled token changed.");

    property p_busy_after_request;
        @(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready;
    endproperty
    a_busy_after_request: assert property (p_busy_after_request)
        else $error("Block took a second request while still busy.");

    property p_zero_alone;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[4:0] == itwt_pkg::TOK_ZERO) |-> m_tlast;
    endproperty
    a_zero_alone: assert property (p_zero_alone) else $error("Zero token not marked last.");

    property p_zero_request;
        @(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[30:0] == 31'd0) && !m_tvalid
            |=> ##1 m_tvalid && m_tlast && (m_tdata[4:0] == itwt_pkg::TOK_ZERO);
    endproperty
    a_zero_request: assert property (p_zero_request)
        else $error("Zero request did not give a single zero token.");

    property p_pad_clear;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:5] == 3'd0);
    endproperty
    a_pad_clear: assert property (p_pad_clear) else $error("Token padding bits set.");

endmodule

bind integer_to_word_tokens itwt_checker u_itwt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam logic [itwt_pkg::WORD_W-1:0] TOK_THOUSAND = 5'd29;
    localparam logic [itwt_pkg::WORD_W-1:0] TOK_MILLION  = 5'd30;
    localparam logic [itwt_pkg::WORD_W-1:0] TOK_BILLION  = 5'd31;

    localparam int RANDOM_REQUESTS = 300;
    localparam int LONG_HOLD_AT    = 500;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int TAIL_CYCLES     = 60;

    typedef struct packed {
        logic [itwt_pkg::WORD_W-1:0] word;
        logic                        last;
    } token_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // [30:0] value, [31] zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [4:0] word, [7:5] zero fill
    logic        m_tlast;

    logic [itwt_pkg::VALUE_W-1:0] pending_values[$];
    token_t                       expected_tokens[$];
    int                           total_requests;
    int                           accepted_requests;
    int                           checked_tokens;
    int                           errors;
    int                           send_gap;
    int                           ready_gap;
    int                           idle_cycles;
    bit                           send_calm;
    bit                           ready_calm;
    bit                           long_hold_done;

    integer_to_word_tokens i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic void push_token(logic [itwt_pkg::WORD_W-1:0] word);
        token_t t;
        t.word = word;
        t.last = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void push_group(int unsigned grp);
        int unsigned hund;
        int unsigned rest;
        hund = grp / 100;
        rest = grp % 100;
        if (hund != 0)
        begin
            push_token(itwt_pkg::WORD_W'(hund));
            push_token(itwt_pkg::TOK_HUNDRED);
        end
        if (rest >= 20)
        begin
            push_token(itwt_pkg::TOK_TENS0 + itwt_pkg::WORD_W'(rest / 10));
            rest = rest % 10;
        end
        if (rest != 0)
            push_token(itwt_pkg::WORD_W'(rest));
    endfunction

    function automatic void predict_tokens(logic [itwt_pkg::VALUE_W-1:0] value);
        int unsigned v;
        int unsigned grp;
        token_t      t;
        v = {1'b0, value};
        if (v == 0)
        begin
            push_token(itwt_pkg::TOK_ZERO);
        end
        else
        begin
            grp = v / 1000000000;
            if (grp != 0)
            begin
                push_group(grp);
                push_token(TOK_BILLION);
            end
            grp = (v / 1000000) % 1000;
            if (grp != 0)
            begin
                push_group(grp);
                push_token(TOK_MILLION);
            end
            grp = (v / 1000) % 1000;
            if (grp != 0)
            begin
                push_group(grp);
                push_token(TOK_THOUSAND);
            end
            grp = v % 1000;
            if (grp != 0)
                push_group(grp);
        end
        t = expected_tokens.pop_back();
        t.last = 1'b1;
        expected_tokens.push_back(t);
    endfunction

    function automatic int unsigned random_group();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $urandom_range(1, 19);
            2: return $urandom_range(1, 9) * 100 + $urandom_range(0, 19);
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    function automatic logic [itwt_pkg::VALUE_W-1:0] random_value();
        longint unsigned v;
        if ($urandom_range(0, 2) == 0)
            return itwt_pkg::VALUE_W'($urandom());
        v = longint'($urandom_range(0, 2)) * 1000000000
            + longint'(random_group()) * 1000000
            + longint'(random_group()) * 1000
            + longint'(random_group());
        if (v > 64'd2147483647)
            v = v - 64'd1000000000;
        return itwt_pkg::VALUE_W'(v);
    endfunction

    // Request side: offers queued values and predicts the tokens of each one taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                predict_tokens(s_tdata[itwt_pkg::VALUE_W-1:0]);
                accepted_requests++;
            end
            if ($urandom_range(0, 29) == 0)
                send_calm = !send_calm;
            if (send_gap != 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_values.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, pending_values.pop_front()};
                send_gap <= pick_gap(send_calm);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Token side: checks every token taken and throttles m_tready.
    always @(posedge clk or negedge rst_n)
    begin
        token_t exp_tok;
        int     g;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            ready_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                checked_tokens++;
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token: word %0d last %0b",
                           m_tdata[itwt_pkg::WORD_W-1:0], m_tlast);
                    errors++;
                end
                else
                begin
                    exp_tok = expected_tokens.pop_front();
                    if (m_tdata[itwt_pkg::WORD_W-1:0] !== exp_tok.word)
                    begin
                        $error("word: expected %0d, got %0d", exp_tok.word,
                               m_tdata[itwt_pkg::WORD_W-1:0]);
                        errors++;
                    end
                    if (m_tlast !== exp_tok.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_tok.last, m_tlast);
                        errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    ready_calm = !ready_calm;
            end
            if (!long_hold_done && checked_tokens >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                m_tready  <= 1'b0;
                ready_gap <= LONG_HOLD;
            end
            else if (ready_gap != 0)
            begin
                m_tready  <= 1'b0;
                ready_gap <= ready_gap - 1;
            end
            else if (m_tvalid && m_tready)
            begin
                g = pick_gap(ready_calm);
                m_tready  <= (g == 0);
                ready_gap <= (g == 0) ? 0 : g - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned directed[$];
        directed = '{0, 1, 9, 10, 11, 13, 19, 20, 21, 99, 100, 101, 110, 119, 999,
                     1000, 1001, 12345, 1000000, 1100011, 1000000000, 1999999999,
                     2000000000, 1073741824, 2147483647};
        foreach (directed[i])
            pending_values.push_back(itwt_pkg::VALUE_W'(directed[i]));
        for (int i = 0; i < RANDOM_REQUESTS; i++)
            pending_values.push_back(random_value());
        total_requests = pending_values.size();

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_requests != total_requests || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
design/itwt_pkg.sv
design/integer_to_word_tokens.sv
design/itwt_checker.sv
bench/tb_top.sv
